@@ rtl/core/gct_pkg.sv @@
// Package for the group completion tracker.
// Holds table sizing constants, field widths, result codes and the
// command/status structs shared by the controller and the datapath.
package gct_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Port field widths
  localparam int KEY_PORT_W  = 16;
  localparam int SIZE_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int ENTRIES_W   = 7;

  // One table word: key, expected count, arrived count
  localparam int ENT_W       = KEY_BITS + 2 * SIZE_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_WAIT = 2'd0,
    ST_DONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic cap;     // latch the arriving word and register the key match
    logic look;    // resolve the slot and read the table
    logic commit;  // update the table and load the result register
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // result register holds a word that is not taken this cycle
  } stat_t;

endpackage

@@ rtl/core/gct_in_if.sv @@
// Arrival channel: valid/ready handshake with key and size payload.
// Depends on gct_pkg for field widths.
interface gct_in_if;
  logic                             valid;
  logic                             ready;
  logic [gct_pkg::KEY_PORT_W-1:0]   group_key;
  logic [gct_pkg::SIZE_W-1:0]       group_size;

  modport source (output valid, group_key, group_size, input ready);
  modport sink   (input valid, group_key, group_size, output ready);
endinterface

@@ rtl/core/gct_out_if.sv @@
// Result channel: valid/ready handshake with status, count and occupancy.
// Depends on gct_pkg for field widths.
interface gct_out_if;
  logic                             valid;
  logic                             ready;
  logic [gct_pkg::STATUS_W-1:0]     status;
  logic [gct_pkg::SIZE_W-1:0]       arrived_count;
  logic [gct_pkg::ENTRIES_W-1:0]    entries_in_use;

  modport source (output valid, status, arrived_count, entries_in_use, input ready);
  modport sink   (input valid, status, arrived_count, entries_in_use, output ready);
endinterface

@@ rtl/core/gct_ctrl.sv @@
// Controller for the group completion tracker: three-state sequencer.
// Depends on gct_pkg; drives commands into gct_dp and reads its status.
module gct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gct_pkg::stat_t  stat,
  output gct_pkg::cmd_t   cmd
);
  import gct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands from the current state; take nothing while in reset
  always_comb begin
    in_ready   = (state == S_IDLE) && !rst;
    cmd.cap    = (state == S_IDLE) && in_valid && !rst;
    cmd.look   = (state == S_LOOK);
    cmd.commit = (state == S_UPD) && !stat.out_busy;
  end

  // Advance through match, lookup and update
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cap, cmd.look, cmd.commit}))
    else $error("more than one command active");

  // A lookup always follows a capture
  a_cap_then_look: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> cmd.look)
    else $error("capture not followed by lookup");

  // Nothing is taken while an item is in flight
  a_no_cap_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.look |=> !cmd.cap)
    else $error("capture during update");

endmodule

@@ rtl/core/gct_dp.sv @@
// Datapath for the group completion tracker: key match lanes, entry memory,
// open count and result register. Depends on gct_pkg; commanded by gct_ctrl.
module gct_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  gct_pkg::cmd_t                     cmd,
  output gct_pkg::stat_t                    stat,
  input  logic [gct_pkg::KEY_PORT_W-1:0]    group_key,
  input  logic [gct_pkg::SIZE_W-1:0]        group_size,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gct_pkg::STATUS_W-1:0]      status,
  output logic [gct_pkg::SIZE_W-1:0]        arrived_count,
  output logic [gct_pkg::ENTRIES_W-1:0]     entries_in_use
);
  import gct_pkg::*;

  // Entry memory and per-lane key copies used for matching
  logic [ENT_W-1:0]     ent_mem  [TABLE_DEPTH];
  logic [KEY_BITS-1:0]  key_lane [TABLE_DEPTH];

  logic [CNT_W-1:0]       open_count;
  logic [KEY_BITS-1:0]    key_q;
  logic [SIZE_W-1:0]      size_q;
  logic [TABLE_DEPTH-1:0] hit_q;
  logic [TABLE_DEPTH-1:0] hit_next;
  logic [IDX_W-1:0]       slot_q;
  logic                   found_q;
  logic                   full_q;
  logic [ENT_W-1:0]       rd_a;
  logic [ENT_W-1:0]       rd_b;

  logic [KEY_BITS-1:0]    key_in;
  logic [IDX_W-1:0]       hit_idx;
  logic                   found;
  logic                   full;
  logic [IDX_W-1:0]       slot_sel;
  logic [CNT_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       last_sel;

  logic                   new_entry;
  logic                   track;
  logic [SIZE_W-1:0]      cur_exp;
  logic [SIZE_W-1:0]      cur_arr;
  logic [SIZE_W-1:0]      arr_n;
  logic                   done;
  logic [CNT_W-1:0]       cnt_add;
  logic [CNT_W-1:0]       cnt_new;
  logic [IDX_W-1:0]       last_after;
  logic                   wr_en;
  logic [ENT_W-1:0]       wr_data;
  status_t                res_status;

  // Compare the arriving key against every open lane
  assign key_in = KEY_BITS'(group_key);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_next[i] = (CNT_W'(i) < open_count) && (key_lane[i] == key_in);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      key_q  <= key_in;
      size_q <= group_size;
      hit_q  <= hit_next;
    end
  end

  // Encode the single hit into a slot index
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_q[i]) hit_idx = hit_idx | IDX_W'(i);
    end
    found    = |hit_q;
    full     = (open_count == CNT_W'(TABLE_DEPTH));
    slot_sel = found ? hit_idx : open_count[IDX_W-1:0];
    cnt_m1   = open_count - CNT_W'(1);
    last_sel = cnt_m1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      slot_q  <= slot_sel;
      found_q <= found;
      full_q  <= full;
    end
  end

  // Update: bump the count, release on completion, refill the hole; a full-table miss changes nothing
  always_comb begin
    new_entry  = !found_q && !full_q;
    track      = found_q || new_entry;
    cur_exp    = new_entry ? size_q : rd_a[SIZE_W +: SIZE_W];
    cur_arr    = new_entry ? '0 : rd_a[SIZE_W-1:0];
    arr_n      = cur_arr + SIZE_W'(1);
    done       = (arr_n >= cur_exp);
    cnt_add    = open_count + CNT_W'(new_entry);
    cnt_new    = cnt_add;
    last_after = slot_q;
    wr_en      = 1'b0;
    wr_data    = {key_q, cur_exp, arr_n};
    res_status = ST_FULL;
    if (track) begin
      last_after = cnt_m1[IDX_W-1:0];
      if (done) begin
        res_status = ST_DONE;
        cnt_new    = cnt_add - CNT_W'(1);
        // A new entry that completes at once is simply never kept
        wr_en      = cmd.commit && !new_entry && (slot_q != last_after);
        wr_data    = rd_b;
      end else begin
        res_status = ST_WAIT;
        wr_en      = cmd.commit;
      end
    end
  end

  // Entry memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rd_a <= ent_mem[slot_sel];
      rd_b <= ent_mem[last_sel];
    end
    if (wr_en) begin
      ent_mem[slot_q] <= wr_data;
    end
  end

  // Key lanes follow every memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_lane[slot_q] <= wr_data[ENT_W-1 -: KEY_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= '0;
    end else if (cmd.commit) begin
      open_count <= cnt_new;
    end
  end

  // Result register
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= STATUS_W'(res_status);
      arrived_count  <= track ? arr_n : '0;
      entries_in_use <= ENTRIES_W'(cnt_new);
    end
  end

  // Occupancy never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= CNT_W'(TABLE_DEPTH))
    else $error("open count beyond table depth");

  // Open keys are unique, so at most one lane hits
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.look |-> $onehot0(hit_q))
    else $error("duplicate key in table");

  // An untracked arrival leaves the table untouched
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !track) |-> !wr_en && (cnt_new == open_count))
    else $error("table changed on untracked arrival");

endmodule

@@ rtl/core/group_completion_tracker_top.sv @@
// Top level of the group completion tracker.
// Depends on gct_pkg, gct_in_if, gct_out_if, gct_ctrl and gct_dp.
//
//   channel   dir   fields
//   in_ch     in    group_key[15:0], group_size[3:0]
//   out_ch    out   status[1:0], arrived_count[3:0], entries_in_use[6:0]
//
// Each arrival runs three steps: key match against all open lanes, slot
// resolve with table read, then update. The registered memory read sets this.
// The result word is registered; a stalled output holds the update step.
// Synchronous active-high reset clears the open count; table contents are
// not cleared and need no clearing pass.
module group_completion_tracker_top (
  input  logic       clk,
  input  logic       rst,
  gct_in_if.sink     in_ch,
  gct_out_if.source  out_ch
);
  import gct_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gct_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .group_key      (in_ch.group_key),
    .group_size     (in_ch.group_size),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .arrived_count  (out_ch.arrived_count),
    .entries_in_use (out_ch.entries_in_use)
  );

endmodule
